// ===== sv/etmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etmc_pkg
// types, constants and helpers shared by the euler trs matrix composer
// ----------------------------------------------------------------------------
package etmc_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int ANGLE_W        = ANGLE_BITS_DEF;
    localparam int VALUE_W        = VALUE_BITS_DEF;
    localparam int POLY_TERMS     = 7;

    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

    // signed q30, raw range [-2^31, 2^31 - 1]
    typedef logic signed [31:0] t_q30;

    // horner coefficients, index 0 is the constant term
    localparam logic signed [31:0] POLY_COEF [POLY_TERMS] = '{
        32'sd1686629713, -32'sd693598668, 32'sd85569306, -32'sd5026995,
        32'sd172272, -32'sd3864, 32'sd61
    };

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_x;
        logic signed [ANGLE_W-1:0] angle_y;
        logic signed [ANGLE_W-1:0] angle_z;
        logic signed [VALUE_W-1:0] scale_x;
        logic signed [VALUE_W-1:0] scale_y;
        logic signed [VALUE_W-1:0] scale_z;
        logic signed [VALUE_W-1:0] loc_x;
        logic signed [VALUE_W-1:0] loc_y;
        logic signed [VALUE_W-1:0] loc_z;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] m00;
        logic signed [VALUE_W-1:0] m01;
        logic signed [VALUE_W-1:0] m02;
        logic signed [VALUE_W-1:0] m10;
        logic signed [VALUE_W-1:0] m11;
        logic signed [VALUE_W-1:0] m12;
        logic signed [VALUE_W-1:0] m20;
        logic signed [VALUE_W-1:0] m21;
        logic signed [VALUE_W-1:0] m22;
        logic signed [VALUE_W-1:0] t_x;
        logic signed [VALUE_W-1:0] t_y;
        logic signed [VALUE_W-1:0] t_z;
    } t_out_item;

    // floor((a*b) >> 30) of two q30 values
    function automatic t_q30 qmul(input t_q30 a, input t_q30 b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return t_q30'(p >>> 30);
    endfunction

endpackage
`default_nettype wire

// ===== sv/etmc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etmc_cell
// one stage cell of the composer chain: a q30 work set, one multiply per lane
// ----------------------------------------------------------------------------
module etmc_cell
    import etmc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_adv,
    input  wire                    i_vld,
    input  wire  etmc_pkg::t_q30   i_w [16],
    input  etmc_pkg::t_in_item     i_it,
    output logic                   o_vld,
    output etmc_pkg::t_q30         o_w [16],
    output etmc_pkg::t_in_item     o_it
);
    // work set: lanes 0..5 hold u/acc of the six quarter waves, 6..11 hold v,
    // 12..14 hold the angle quadrants and residues packed, 15 unused

    t_q30 n_w [16];

    always_comb begin
        n_w = i_w;
        if (STAGE == 0) begin
            for (int k = 0; k < 6; k++) begin
                n_w[6+k] = qmul(i_w[k], i_w[k]);
                n_w[k]   = i_w[k];
            end
        end else if (STAGE <= POLY_TERMS - 1) begin
            // horner step
            for (int k = 0; k < 6; k++)
                n_w[k] = POLY_COEF[POLY_TERMS-1-STAGE] +
                    qmul((STAGE == 1) ? POLY_COEF[POLY_TERMS-1] : i_w[k], i_w[6+k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_adv) begin
            o_vld <= i_vld;
        end
        if (i_adv) begin
            o_w  <= n_w;
            o_it <= i_it;
        end
    end

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n) !i_adv |=> $stable(o_vld);
    endproperty
    a_hold: assert property (p_hold) else $error("cell valid moved while held");

    property p_load;
        @(posedge i_clk) disable iff (!i_rst_n) i_adv |=> o_vld == $past(i_vld);
    endproperty
    a_load: assert property (p_load) else $error("cell valid not loaded");

    property p_rst;
        @(posedge i_clk) !i_rst_n |=> !o_vld;
    endproperty
    a_rst: assert property (p_rst) else $error("cell valid not cleared");

endmodule
`default_nettype wire

// ===== sv/etmc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etmc_back
// quadrant fold, matrix products, column scaling and saturation, as stages
// ----------------------------------------------------------------------------
module etmc_back
    import etmc_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_adv,
    input  wire                    i_vld,
    input  wire  etmc_pkg::t_q30   i_w [16],
    input  etmc_pkg::t_in_item     i_it,
    output logic                   o_vld,
    output etmc_pkg::t_out_item    o_res
);
    // stage a: last multiply u*acc, clamp, fold quadrant
    // stage b: pair products; stage c: triple products and brackets
    // stage d: scale products (34x32); stage e: truncate and saturate

    t_q30     r_sn [3], r_cs [3];
    t_in_item r_ita, r_itb, r_itc, r_itd;
    logic     r_va, r_vb, r_vc, r_vd;
    t_q30     r_p [9];   // cy cz, sy sx, cy sx, cz sy, cx sz, cx cz, cy sz, sy sz, cx sy
    t_q30     r_cxx, r_sxx, r_szx;
    logic signed [33:0] r_t [9];
    logic signed [VALUE_W+34:0] r_m [9];

    function automatic t_q30 clampq(input t_q30 a);
        if (a < 0) return '0;
        if (a > Q30_ONE) return Q30_ONE;
        return a;
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat(input logic signed [VALUE_W+34:0] p);
        logic signed [VALUE_W+34:0] q;
        logic signed [VALUE_W+34:0] hi, lo;
        // round toward zero
        q  = (p < 0) ? -((-p) >>> 30) : (p >>> 30);
        hi = (VALUE_W+35)'((64'sd1 <<< (VALUE_W-1)) - 64'sd1);
        lo = ~hi;
        if (q > hi) return hi[VALUE_W-1:0];
        if (q < lo) return lo[VALUE_W-1:0];
        return q[VALUE_W-1:0];
    endfunction

    t_q30 n_sn [3], n_cs [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            t_q30 s, c;
            logic [1:0] q;
            s = clampq(qmul(i_w[a], i_w[12+a] & 32'sh3FFF_FFFF));
            c = clampq(qmul(i_w[3+a], Q30_ONE - (i_w[12+a] & 32'sh3FFF_FFFF)));
            q = i_w[12+a][31:30];
            case (q)
                2'd0:    begin n_sn[a] = s;  n_cs[a] = c;  end
                2'd1:    begin n_sn[a] = c;  n_cs[a] = -s; end
                2'd2:    begin n_sn[a] = -s; n_cs[a] = -c; end
                default: begin n_sn[a] = -c; n_cs[a] = s;  end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0; r_vd <= 1'b0; o_vld <= 1'b0;
        end else if (i_adv) begin
            r_va <= i_vld; r_vb <= r_va; r_vc <= r_vb; r_vd <= r_vc; o_vld <= r_vd;
        end
        if (i_adv) begin
            r_sn <= n_sn; r_cs <= n_cs; r_ita <= i_it;
            // index 0 x, 1 y, 2 z
            r_p[0] <= qmul(r_cs[1], r_cs[2]);
            r_p[1] <= qmul(r_sn[1], r_sn[0]);
            r_p[2] <= qmul(r_cs[1], r_sn[0]);
            r_p[3] <= qmul(r_cs[2], r_sn[1]);
            r_p[4] <= qmul(r_cs[0], r_sn[2]);
            r_p[5] <= qmul(r_cs[0], r_cs[2]);
            r_p[6] <= qmul(r_cs[1], r_sn[2]);
            r_p[7] <= qmul(r_sn[1], r_sn[2]);
            r_p[8] <= qmul(r_cs[0], r_sn[1]);
            r_cxx <= qmul(r_cs[1], r_cs[0]);
            r_sxx <= r_sn[0]; r_szx <= r_sn[2];
            r_itb <= r_ita;
            r_t[0] <= 34'(qmul(r_p[1], r_szx)) + 34'(r_p[0]);
            r_t[1] <= 34'(r_p[4]);
            r_t[2] <= 34'(qmul(r_p[2], r_szx)) - 34'(r_p[3]);
            r_t[3] <= 34'(qmul(r_p[3], r_sxx)) - 34'(r_p[6]);
            r_t[4] <= 34'(r_p[5]);
            r_t[5] <= 34'(qmul(r_p[0], r_sxx)) + 34'(r_p[7]);
            r_t[6] <= 34'(r_p[8]);
            r_t[7] <= -34'(r_sxx);
            r_t[8] <= 34'(r_cxx);
            r_itc <= r_itb;
            for (int k = 0; k < 9; k++)
                r_m[k] <= (VALUE_W+35)'(r_t[k]) * (VALUE_W+35)'(
                    (k < 3) ? r_itc.scale_x : (k < 6) ? r_itc.scale_y : r_itc.scale_z);
            r_itd <= r_itc;
            o_res.m00 <= sat(r_m[0]); o_res.m01 <= sat(r_m[1]); o_res.m02 <= sat(r_m[2]);
            o_res.m10 <= sat(r_m[3]); o_res.m11 <= sat(r_m[4]); o_res.m12 <= sat(r_m[5]);
            o_res.m20 <= sat(r_m[6]); o_res.m21 <= sat(r_m[7]); o_res.m22 <= sat(r_m[8]);
            o_res.t_x <= r_itd.loc_x; o_res.t_y <= r_itd.loc_y; o_res.t_z <= r_itd.loc_z;
        end
    end

    property p_chain;
        @(posedge i_clk) disable iff (!i_rst_n) i_adv |=> r_vb == $past(r_va);
    endproperty
    a_chain: assert property (p_chain) else $error("back valid chain broken");

    property p_trans;
        @(posedge i_clk) disable iff (!i_rst_n) i_adv |=> o_res.t_x == $past(r_itd.loc_x);
    endproperty
    a_trans: assert property (p_trans) else $error("translation not carried");

    property p_m21;
        @(posedge i_clk) disable iff (!i_rst_n) i_adv |=> r_t[7] == -34'($past(r_sxx));
    endproperty
    a_m21: assert property (p_m21) else $error("m21 bracket wrong");

endmodule
`default_nettype wire

// ===== sv/euler_trs_matrix_compose.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_trs_matrix_compose
// yxz euler angles, scales and location to a 3x4 scaled transform
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in      | input     | i_valid / o_stall | t_in_item
//  out     | output    | o_valid / i_stall | t_out_item
//
//  one transfer per cycle in while not stalled; 7 cells (square and 6 horner
//  steps), then 5 back stages
//  the whole chain advances together; i_stall with a full output holds it
//  o_stall is high only when the output is full and stalled
//  synchronous active low reset clears valid flags only
// ----------------------------------------------------------------------------
module euler_trs_matrix_compose
    import etmc_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  etmc_pkg::t_in_item     i_data,
    output logic                   o_valid,
    input  wire                    i_stall,
    output etmc_pkg::t_out_item    o_data
);
    localparam int NCELL = POLY_TERMS;

    logic     adv;
    t_q30     ph   [3];
    t_q30     w_in [16];
    t_q30     w   [NCELL+1][16];
    logic     v   [NCELL+1];
    t_in_item it  [NCELL+1];

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // lane setup: residue r and 1-r for each axis, phase kept for quadrant
    always_comb begin
        ph[0] = t_q30'({i_data.angle_x, {(32-ANGLE_W){1'b0}}});
        ph[1] = t_q30'({i_data.angle_y, {(32-ANGLE_W){1'b0}}});
        ph[2] = t_q30'({i_data.angle_z, {(32-ANGLE_W){1'b0}}});
        for (int k = 0; k < 16; k++) w_in[k] = '0;
        for (int a = 0; a < 3; a++) begin
            w_in[a]    = ph[a] & 32'sh3FFF_FFFF;
            w_in[3+a]  = Q30_ONE - (ph[a] & 32'sh3FFF_FFFF);
            w_in[12+a] = ph[a];
        end
    end

    assign w[0]  = w_in;
    assign v[0]  = i_valid;
    assign it[0] = i_data;

    // horner stages keep u in lanes 0..5 only until stage 0 uses it, so carry
    // the phase in lanes 12..14; the back end rebuilds u from it
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        etmc_cell #(.STAGE(g)) u_cell (
            .i_clk, .i_rst_n, .i_adv(adv),
            .i_vld(v[g]), .i_w(w[g]), .i_it(it[g]),
            .o_vld(v[g+1]), .o_w(w[g+1]), .o_it(it[g+1])
        );
    end

    etmc_back u_back (
        .i_clk, .i_rst_n, .i_adv(adv),
        .i_vld(v[NCELL]), .i_w(w[NCELL]), .i_it(it[NCELL]),
        .o_vld(o_valid), .o_res(o_data)
    );

    property p_stall;
        @(posedge i_clk) disable iff (!i_rst_n) o_stall |-> o_valid;
    endproperty
    a_stall: assert property (p_stall) else $error("stall without result");

    property p_keep;
        @(posedge i_clk) disable iff (!i_rst_n) (o_valid && i_stall) |=> o_valid;
    endproperty
    a_keep: assert property (p_keep) else $error("stalled result dropped");

    property p_free;
        @(posedge i_clk) disable iff (!i_rst_n) !i_stall |-> !o_stall;
    endproperty
    a_free: assert property (p_free) else $error("input stalled without output stall");

endmodule
`default_nettype wire

// ===== tb/euler_trs_matrix_compose_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_trs_matrix_compose_tb
// drives random and edge-case angle, scale and location items through the
// composer under several idle and stall mixes and checks every matrix entry
// against a fixed-point model of the yxz transform
// ----------------------------------------------------------------------------
module euler_trs_matrix_compose_tb;
    import etmc_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    // fixed-point model of one transform, compared in arrival order
    class matrix_board;
        t_out_item pending[$];
        int        mismatches;
        int        checked;

        function longint fmul(longint a, longint b);
            return (a * b) >>> 30;
        endfunction

        function longint quarter_wave(longint u);
            longint v, acc;
            v   = fmul(u, u);
            acc = 61;
            acc = -3864 + fmul(acc, v);
            acc = 172272 + fmul(acc, v);
            acc = -5026995 + fmul(acc, v);
            acc = 85569306 + fmul(acc, v);
            acc = -693598668 + fmul(acc, v);
            acc = 1686629713 + fmul(acc, v);
            acc = fmul(acc, u);
            if (acc < 0) acc = 0;
            if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
            return acc;
        endfunction

        function void sin_cos(logic [15:0] ang, output longint sn, output longint cs);
            logic [31:0] ph;
            longint      r, s, c;
            ph = {ang, 16'h0};
            r  = longint'(ph[29:0]);
            s  = quarter_wave(r);
            c  = quarter_wave((64'sd1 << 30) - r);
            case (ph[31:30])
                2'd0: begin sn = s;  cs = c;  end
                2'd1: begin sn = c;  cs = -s; end
                2'd2: begin sn = -s; cs = -c; end
                default: begin sn = -c; cs = s; end
            endcase
        endfunction

        function logic [31:0] scaled(longint t, logic signed [31:0] k);
            logic signed [127:0] p, q;
            p = 128'(t) * 128'(longint'(k));
            q = (p < 0) ? -((-p) >>> 30) : (p >>> 30);
            if (q > 128'sh7fff_ffff) q = 128'sh7fff_ffff;
            if (q < -128'sh8000_0000) q = -128'sh8000_0000;
            return q[31:0];
        endfunction

        function void note_input(t_in_item it);
            longint    sx, cx, sy, cy, sz, cz;
            t_out_item m;
            sin_cos(it.angle_x, sx, cx);
            sin_cos(it.angle_y, sy, cy);
            sin_cos(it.angle_z, sz, cz);
            m.m00 = scaled(fmul(cy, cz) + fmul(fmul(sy, sx), sz), it.scale_x);
            m.m01 = scaled(fmul(cx, sz), it.scale_x);
            m.m02 = scaled(fmul(fmul(cy, sx), sz) - fmul(cz, sy), it.scale_x);
            m.m10 = scaled(fmul(fmul(cz, sy), sx) - fmul(cy, sz), it.scale_y);
            m.m11 = scaled(fmul(cx, cz), it.scale_y);
            m.m12 = scaled(fmul(fmul(cy, cz), sx) + fmul(sy, sz), it.scale_y);
            m.m20 = scaled(fmul(cx, sy), it.scale_z);
            m.m21 = scaled(-sx, it.scale_z);
            m.m22 = scaled(fmul(cy, cx), it.scale_z);
            m.t_x = it.loc_x;
            m.t_y = it.loc_y;
            m.t_z = it.loc_z;
            pending.push_back(m);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d\n  expected %h\n  actual   %h",
                             checked, want, got);
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_stall = 1'b0;
    t_in_item  in_item = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    matrix_board board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int sent = 0;
    int idle_cycles = 0;
    bit timed_out = 0;

    always #2 clk = ~clk;

    euler_trs_matrix_compose u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_item),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_item)
    );

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) board.note_input(in_item);
            if (out_valid && !out_stall) board.check_result(out_item);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else if (in_valid || board.pending.size() != 0) begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // holds the item until its transfer, with random idle cycles ahead of it
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    function automatic t_in_item random_item();
        t_in_item     it;
        logic [287:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom};
        it = bits[$bits(t_in_item)-1:0];
        // mostly moderate scales so entries rarely saturate
        if ($urandom_range(3) != 0) begin
            it.scale_x = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            it.scale_y = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            it.scale_z = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        end
        return it;
    endfunction

    initial begin
        t_in_item it;
        logic signed [15:0] edge_angles [6] = '{16'sh8000, 16'sh7fff, 16'sh0000,
                                                16'sh4000, 16'shc000, 16'sh0001};
        logic signed [31:0] edge_scales [5] = '{32'sh8000_0000, 32'sh7fff_ffff,
                                                32'sh0001_0000, 32'shffff_0000, 32'sh0};
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extreme angles and scales, including saturating ones
        for (int i = 0; i < 24; i++) begin
            it = random_item();
            it.angle_x = edge_angles[i % 6];
            it.angle_y = edge_angles[(i / 2) % 6];
            it.angle_z = edge_angles[(i / 4) % 6];
            it.scale_x = edge_scales[i % 5];
            it.scale_y = edge_scales[(i + 1) % 5];
            it.scale_z = edge_scales[(i + 3) % 5];
            if (i == 0) it = {{3{16'h8000}}, {6{32'h8000_0000}}};
            if (i == 1) it = '1 >> 1;
            send_item(it);
        end

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                3: begin send_idle_pct = 21; recv_stall_pct = 21; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (106) send_item(random_item());
        end
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        wait (board.pending.size() == 0 || timed_out);
        repeat (20) @(posedge clk);
        $display("sent %0d transforms, %0d results checked over five idle/stall mixes",
                 sent, board.checked);
        if (!timed_out && board.mismatches == 0 && board.pending.size() == 0) begin
            $display("euler_trs_matrix_compose test passed");
        end else begin
            $display("euler_trs_matrix_compose test failed");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        timed_out = 1;
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("euler_trs_matrix_compose test failed");
        $finish;
    end
endmodule
